FILE: hdl/dcp_pkg.sv
// shared types, constants and helpers of the distance constraint projection block
package dcp_pkg;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_STIFFNESS    = 1'b0,
    REG_MIN_MASS_SUM = 1'b1
  } cfg_reg_t;

  localparam logic [16:0] STIFFNESS_RESET = 17'd65536;
  localparam logic [15:0] MIN_MASS_RESET  = 16'd1;

  // unit sizes
  localparam int ROOT_W   = 32;  // floor square root bits
  localparam int RATIO_QW = 33;  // mass ratio quotient bits, up to 2^32
  localparam int DIR_QW   = 31;  // direction quotient bits, up to 2^30 + 1

  // pipeline stage numbers, entry register is stage 0
  localparam int STAGE_RATIO = 34;  // mass ratio dividers done
  localparam int STAGE_ROOT  = 35;  // square root done
  localparam int STAGE_DIR   = 67;  // direction dividers done
  localparam int LAST_STAGE  = 70;  // output register

  localparam int SIDE_LEN    = 69;  // side data held for stages 1 to 69
  localparam int ERR_LEN     = 34;  // error sign held for stages 36 to 69
  localparam int RATIO_DELAY = 3;   // ratio wait from stage 35 to 37
  localparam int SCALE_DELAY = 29;  // scaled correction wait from stage 39 to 67

  typedef struct packed {
    logic [2:0][31:0] p1;
    logic [2:0][31:0] p2;
    logic [2:0][31:0] mag;
    logic [2:0]       dneg;
    logic             big;
    logic             skip;
    logic [30:0]      rest;
  } side_t;

  typedef struct packed {
    logic eneg;
    logic dz;
  } err_t;

  function automatic logic [31:0] sat32(input logic [36:0] v);
    logic [31:0] r;
    if (!v[36] && (|v[35:31])) r = 32'h7fff_ffff;
    else if (v[36] && !(&v[35:31])) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

FILE: hdl/dcp_div.sv
// pipelined restoring divider, one quotient bit per register stage
module dcp_div #(
  parameter int NumW = 64,
  parameter int DenW = 33,
  parameter int QuoW = 33
) (
  input  logic            clk,
  input  logic            en,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic [QuoW-1:0] quo
);

  localparam int RemW = (NumW > DenW + QuoW) ? NumW : DenW + QuoW;

  logic [RemW-1:0] rem [QuoW];
  logic [DenW-1:0] dv  [QuoW];
  logic [QuoW-1:0] qv  [QuoW];

  for (genvar s = 0; s < QuoW; s++) begin : g_stage
    localparam int Bit = QuoW - 1 - s;
    logic [RemW-1:0] rem_in;
    logic [RemW-1:0] trial;
    logic [DenW-1:0] den_in;
    logic [QuoW-1:0] q_in;

    if (s == 0) begin : g_first
      assign rem_in = RemW'(num);
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem[s-1];
      assign den_in = dv[s-1];
      assign q_in   = qv[s-1];
    end

    assign trial = RemW'(den_in) << Bit;

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem[s] <= rem_in - trial;
          qv[s]  <= q_in | (QuoW'(1) << Bit);
        end else begin
          rem[s] <= rem_in;
          qv[s]  <= q_in;
        end
        dv[s] <= den_in;
      end
    end
  end

  assign quo = qv[QuoW-1];

endmodule

FILE: hdl/distance_constraint_projection_top.sv
// distance constraint projection: one stretching constraint per cycle while in_stall is low, stages 0 to 70
//
// input channel: in_valid / in_stall with the two predicted positions, the two
// inverse masses and the rest length; a transaction completes when in_valid is
// high and in_stall is low. output channel: out_valid / out_stall with the six
// corrected coordinates and the skipped flag, same rule.
// configuration: cfg_write_en, cfg_index and cfg_data write stiffness (index 0)
// or min_mass_sum (index 1); write only while the pipeline is empty.
// throughput: one transaction per cycle while in_stall is low. the depth is set
// by the 32-stage square root followed by the 31-stage direction dividers; the
// mass ratio dividers run beside the square root.
// all stages move together: when the output holds a result and out_stall is
// high, in_stall rises and nothing moves; otherwise the pipe advances every
// cycle, bubbles included, so the output register frees up at once.
// reset (rst, synchronous) empties the pipeline and sets stiffness to 1.0 and
// min_mass_sum to 1; data registers are not cleared.
module distance_constraint_projection_top
  import dcp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] first_x,
  input  logic signed [31:0] first_y,
  input  logic signed [31:0] first_z,
  input  logic signed [31:0] second_x,
  input  logic signed [31:0] second_y,
  input  logic signed [31:0] second_z,
  input  logic        [31:0] first_inv_mass,
  input  logic        [31:0] second_inv_mass,
  input  logic        [30:0] rest_length,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] new_first_x,
  output logic signed [31:0] new_first_y,
  output logic signed [31:0] new_first_z,
  output logic signed [31:0] new_second_x,
  output logic signed [31:0] new_second_y,
  output logic signed [31:0] new_second_z,
  output logic               skipped,
  input  logic               cfg_write_en,
  input  logic        [0:0]  cfg_index,
  input  logic        [16:0] cfg_data
);

  logic              adv;
  logic [LAST_STAGE:0] vld;
  logic [16:0]       stiffness;
  logic [15:0]       min_mass_sum;

  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[LAST_STAGE];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST_STAGE-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness    <= STIFFNESS_RESET;
      min_mass_sum <= MIN_MASS_RESET;
    end else if (cfg_write_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_STIFFNESS:    stiffness    <= cfg_data;
        REG_MIN_MASS_SUM: min_mass_sum <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // stage 0: input register
  logic [2:0][31:0] a_p1, a_p2;
  logic [31:0]      a_w1, a_w2;
  logic [30:0]      a_rest;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_p1   <= {first_z, first_y, first_x};
      a_p2   <= {second_z, second_y, second_x};
      a_w1   <= first_inv_mass;
      a_w2   <= second_inv_mass;
      a_rest <= rest_length;
    end
  end

  // stage 1: differences, magnitudes, mass sum
  logic [2:0][32:0] delta;
  logic [32:0]      msum_c;
  side_t            side_c;
  side_t            side [SIDE_LEN];
  logic [31:0]      b_w1, b_w2;
  logic [32:0]      b_msum;

  always_comb begin
    side_c = '0;
    for (int i = 0; i < 3; i++) begin
      delta[i] = {a_p1[i][31], a_p1[i]} - {a_p2[i][31], a_p2[i]};
      side_c.dneg[i] = delta[i][32];
      side_c.mag[i]  = delta[i][32] ? 32'(-delta[i]) : delta[i][31:0];
    end
    msum_c       = {1'b0, a_w1} + {1'b0, a_w2};
    side_c.p1    = a_p1;
    side_c.p2    = a_p2;
    side_c.big   = side_c.mag[0][31] | side_c.mag[1][31] | side_c.mag[2][31];
    side_c.skip  = (msum_c < {17'b0, min_mass_sum}) || (msum_c == 33'd0);
    side_c.rest  = a_rest;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= side_c;
      for (int k = 1; k < SIDE_LEN; k++) side[k] <= side[k-1];
      b_w1   <= a_w1;
      b_w2   <= a_w2;
      b_msum <= msum_c;
    end
  end

  // mass ratios w * 2^32 / (w1 + w2), done at stage 34
  logic [RATIO_QW-1:0] ratio_q [2];

  dcp_div #(.NumW(64), .DenW(33), .QuoW(RATIO_QW)) u_ratio1 (
    .clk(clk), .en(adv), .num({b_w1, 32'b0}), .den(b_msum), .quo(ratio_q[0])
  );
  dcp_div #(.NumW(64), .DenW(33), .QuoW(RATIO_QW)) u_ratio2 (
    .clk(clk), .en(adv), .num({b_w2, 32'b0}), .den(b_msum), .quo(ratio_q[1])
  );

  // stages 2 and 3: squared length
  logic [2:0][30:0] m_c;
  logic [2:0][61:0] sqr;
  logic [63:0]      sq;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_c[i] = side[0].big ? side[0].mag[i][31:1] : side[0].mag[i][30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) sqr[i] <= 62'(m_c[i]) * 62'(m_c[i]);
      sq <= 64'(sqr[0]) + 64'(sqr[1]) + 64'(sqr[2]);
    end
  end

  // stages 4 to 35: floor square root, one root bit per stage
  logic [63:0]       rt_rem  [ROOT_W];
  logic [ROOT_W-1:0] rt_root [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_root
    localparam int Bit = ROOT_W - 1 - s;
    logic [63:0]       rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [65:0]       trial;

    if (s == 0) begin : g_first
      assign rem_in  = sq;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rt_rem[s-1];
      assign root_in = rt_root[s-1];
    end

    // (r + 2^k)^2 - r^2
    assign trial = (66'(root_in) << (Bit + 1)) + (66'(1) << (2 * Bit));

    always_ff @(posedge clk) begin
      if (adv) begin
        if (66'(rem_in) >= trial) begin
          rt_rem[s]  <= rem_in - trial[63:0];
          rt_root[s] <= root_in | (ROOT_W'(1) << Bit);
        end else begin
          rt_rem[s]  <= rem_in;
          rt_root[s] <= root_in;
        end
      end
    end
  end

  // stage 36: distance and length error
  logic [32:0] d_c;
  logic [33:0] e_c;
  logic [32:0] ae_c;
  logic [32:0] e_d;
  logic [32:0] e_ae;
  err_t        err_c;
  err_t        ed [ERR_LEN];

  always_comb begin
    d_c  = side[34].big ? {rt_root[ROOT_W-1], 1'b0} : {1'b0, rt_root[ROOT_W-1]};
    e_c  = {1'b0, d_c} - {3'b0, side[34].rest};
    ae_c = e_c[33] ? 33'(-e_c) : e_c[32:0];
    err_c.eneg = e_c[33];
    err_c.dz   = (d_c == 33'd0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_d   <= d_c;
      e_ae  <= ae_c;
      ed[0] <= err_c;
      for (int k = 1; k < ERR_LEN; k++) ed[k] <= ed[k-1];
    end
  end

  // direction |delta| * 2^30 / d, done at stage 67
  logic [DIR_QW-1:0] dirq [3];

  for (genvar i = 0; i < 3; i++) begin : g_dir
    dcp_div #(.NumW(62), .DenW(33), .QuoW(DIR_QW)) u_dir (
      .clk(clk), .en(adv), .num({side[35].mag[i], 30'b0}), .den(e_d), .quo(dirq[i])
    );
  end

  // stages 37 to 39: k * |e| and its share by mass
  logic [49:0]         ke_prod;
  logic [33:0]         ke;
  logic [RATIO_QW-1:0] rdl [RATIO_DELAY][2];
  logic [64:0]         plo [2];
  logic [34:0]         phi [2];
  logic [35:0]         s_sum [2];
  logic [1:0][33:0]    sdl [SCALE_DELAY];

  assign ke_prod = 50'(stiffness) * 50'(e_ae);

  always_comb begin
    for (int j = 0; j < 2; j++) s_sum[j] = 36'(plo[j][64:32]) + 36'(phi[j]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ke <= ke_prod[49:16];
      for (int j = 0; j < 2; j++) begin
        rdl[0][j] <= ratio_q[j];
        for (int k = 1; k < RATIO_DELAY; k++) rdl[k][j] <= rdl[k-1][j];
        plo[j] <= 65'(ke[31:0]) * 65'(rdl[RATIO_DELAY-1][j]);
        phi[j] <= 35'(ke[33:32]) * 35'(rdl[RATIO_DELAY-1][j]);
        sdl[0][j] <= s_sum[j][33:0];
      end
      for (int k = 1; k < SCALE_DELAY; k++) sdl[k] <= sdl[k-1];
    end
  end

  // stages 68 and 69: corrections per particle and axis
  logic [62:0] clo  [2][3];
  logic [32:0] chi  [2][3];
  logic [34:0] corr [2][3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 2; j++) begin
        for (int i = 0; i < 3; i++) begin
          clo[j][i]  <= 63'(sdl[SCALE_DELAY-1][j][31:0]) * 63'(dirq[i]);
          chi[j][i]  <= 33'(sdl[SCALE_DELAY-1][j][33:32]) * 33'(dirq[i]);
          corr[j][i] <= 35'(36'(clo[j][i][62:30]) + (36'(chi[j][i]) << 2));
        end
      end
    end
  end

  // stage 70: apply, saturate, output register
  logic [2:0][31:0] n1_c, n2_c;
  logic [36:0]      p1w, p2w, c1w, c2w, s1, s2;
  logic             neg, pass;

  always_comb begin
    pass = side[SIDE_LEN-1].skip || ed[ERR_LEN-1].dz;
    p1w = '0; p2w = '0; c1w = '0; c2w = '0; s1 = '0; s2 = '0; neg = 1'b0;
    for (int i = 0; i < 3; i++) begin
      p1w = {{5{side[SIDE_LEN-1].p1[i][31]}}, side[SIDE_LEN-1].p1[i]};
      p2w = {{5{side[SIDE_LEN-1].p2[i][31]}}, side[SIDE_LEN-1].p2[i]};
      c1w = 37'(corr[0][i]);
      c2w = 37'(corr[1][i]);
      neg = ed[ERR_LEN-1].eneg ^ side[SIDE_LEN-1].dneg[i];
      s1  = neg ? p1w + c1w : p1w - c1w;
      s2  = neg ? p2w - c2w : p2w + c2w;
      n1_c[i] = pass ? side[SIDE_LEN-1].p1[i] : sat32(s1);
      n2_c[i] = pass ? side[SIDE_LEN-1].p2[i] : sat32(s2);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      new_first_x  <= n1_c[0];
      new_first_y  <= n1_c[1];
      new_first_z  <= n1_c[2];
      new_second_x <= n2_c[0];
      new_second_y <= n2_c[1];
      new_second_z <= n2_c[2];
      skipped      <= side[SIDE_LEN-1].skip;
    end
  end

`ifndef NO_ASSERTIONS
  // root remainder stays within the floor square root bound
  a_root_floor: assert property (@(posedge clk) disable iff (rst)
    vld[STAGE_ROOT] |->
      (65'(rt_rem[ROOT_W-1]) <= (65'(rt_root[ROOT_W-1]) << 1)))
    else $error("square root remainder out of bound");

  // the two mass ratios add up to one, less at most one unit
  a_ratio_sum: assert property (@(posedge clk) disable iff (rst)
    (vld[STAGE_RATIO] && !side[STAGE_RATIO-1].skip) |->
      ((34'(ratio_q[0]) + 34'(ratio_q[1]) <= (34'(1) << 32)) &&
       (34'(ratio_q[0]) + 34'(ratio_q[1]) >= (34'(1) << 32) - 34'd1)))
    else $error("mass ratios do not sum to one");

  // direction components never exceed one by more than one unit
  a_dir_bound: assert property (@(posedge clk) disable iff (rst)
    (vld[STAGE_DIR] && !ed[STAGE_DIR-36].dz) |->
      ((dirq[0] <= (DIR_QW'(1) << 30) + DIR_QW'(1)) &&
       (dirq[1] <= (DIR_QW'(1) << 30) + DIR_QW'(1)) &&
       (dirq[2] <= (DIR_QW'(1) << 30) + DIR_QW'(1))))
    else $error("direction component out of range");
`endif

endmodule

FILE: sim/tb.sv
// testbench for the distance constraint projection pipeline
module tb;
  import dcp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0][31:0] p1;
    logic [2:0][31:0] p2;
    logic [31:0]      w1;
    logic [31:0]      w2;
    logic [30:0]      rest;
  } constraint_t;

  typedef struct packed {
    logic [2:0][31:0] np1;
    logic [2:0][31:0] np2;
    logic             skip;
  } projection_t;

  localparam int PIPE_DEPTH = 70;
  localparam int DRAIN_WAIT = PIPE_DEPTH + 10;
  localparam int IDLE_LIMIT = 3000;
  localparam int LONG_HOLD  = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  logic cfg_write_en = 1'b0;
  cfg_reg_t cfg_sel = REG_STIFFNESS;
  logic [16:0] cfg_data = '0;
  constraint_t cur = '0;
  logic signed [31:0] new_first_x, new_first_y, new_first_z;
  logic signed [31:0] new_second_x, new_second_y, new_second_z;
  logic skipped;

  constraint_t pending_q[$];
  projection_t expected_q[$];
  logic [16:0] stiff_k = STIFFNESS_RESET;
  logic [15:0] mass_min = MIN_MASS_RESET;
  int errors = 0;
  int accepted_cnt = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_done = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int idle_cycles = 0;

  distance_constraint_projection_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .first_x(cur.p1[0]), .first_y(cur.p1[1]), .first_z(cur.p1[2]),
    .second_x(cur.p2[0]), .second_y(cur.p2[1]), .second_z(cur.p2[2]),
    .first_inv_mass(cur.w1), .second_inv_mass(cur.w2), .rest_length(cur.rest),
    .out_valid(out_valid), .out_stall(out_stall),
    .new_first_x(new_first_x), .new_first_y(new_first_y), .new_first_z(new_first_z),
    .new_second_x(new_second_x), .new_second_y(new_second_y),
    .new_second_z(new_second_z), .skipped(skipped),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_sel), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'h7fff_ffff;
    if (v < -128'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic projection_t project(input constraint_t c, input logic [16:0] k,
                                          input logic [15:0] mmin);
    projection_t res;
    longint dlt [3];
    logic [63:0] mag [3];
    logic [63:0] msum, sq, m, d;
    logic [127:0] ae, ke, r1, r2, s1, s2, q, c1, c2;
    logic signed [127:0] e, a1, a2;
    bit big, eneg, neg;
    res.np1 = c.p1;
    res.np2 = c.p2;
    res.skip = 1'b0;
    big = 0;
    for (int i = 0; i < 3; i++) begin
      dlt[i] = longint'($signed(c.p1[i])) - longint'($signed(c.p2[i]));
      mag[i] = dlt[i] < 0 ? -dlt[i] : dlt[i];
      if (mag[i] >= 64'd2147483648) big = 1;
    end
    msum = {32'b0, c.w1} + {32'b0, c.w2};
    if (msum < {48'b0, mmin} || msum == 0) begin
      res.skip = 1'b1;
      return res;
    end
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      m = big ? mag[i] >> 1 : mag[i];
      sq = sq + m * m;
    end
    d = floor_root(sq);
    if (big) d = d << 1;
    // coincident particles leave the positions as they are
    if (d == 0) return res;
    e = $signed({64'b0, d}) - $signed({97'b0, c.rest});
    eneg = e < 0;
    ae = eneg ? -e : e;
    ke = ({111'b0, k} * ae) >> 16;
    r1 = ({96'b0, c.w1} << 32) / {64'b0, msum};
    r2 = ({96'b0, c.w2} << 32) / {64'b0, msum};
    s1 = (ke * r1) >> 32;
    s2 = (ke * r2) >> 32;
    for (int i = 0; i < 3; i++) begin
      q = ({64'b0, mag[i]} << 30) / {64'b0, d};
      c1 = (s1 * q) >> 30;
      c2 = (s2 * q) >> 30;
      neg = eneg != (dlt[i] < 0);
      a1 = $signed(128'($signed(c.p1[i])));
      a2 = $signed(128'($signed(c.p2[i])));
      res.np1[i] = clamp32(neg ? a1 + $signed(c1) : a1 - $signed(c1));
      res.np2[i] = clamp32(neg ? a2 - $signed(c2) : a2 + $signed(c2));
    end
    return res;
  endfunction

  function automatic logic [31:0] pick_mass();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return $urandom_range(1, 70000);
      2: return $urandom_range(0, 3) << 16;
      3: return $urandom;
      default: return $urandom_range(1, 32'h0008_0000);
    endcase
  endfunction

  function automatic constraint_t random_constraint();
    constraint_t c;
    int span;
    logic [31:0] base;
    c.w1 = pick_mass();
    c.w2 = pick_mass();
    if ($urandom_range(0, 9) < 2) begin
      for (int i = 0; i < 3; i++) begin
        c.p1[i] = $urandom;
        c.p2[i] = $urandom;
      end
      c.rest = 31'($urandom);
    end else begin
      // nearby particles, rest length around their separation
      span = 1 << $urandom_range(4, 24);
      for (int i = 0; i < 3; i++) begin
        base = $urandom;
        c.p1[i] = base;
        c.p2[i] = base + $urandom_range(0, 2 * span) - span;
      end
      c.rest = 31'($urandom_range(0, 2 * span));
    end
    return c;
  endfunction

  function automatic constraint_t make_pair(input logic [31:0] ax, ay, az, bx, by, bz,
                                            input logic [31:0] w1, w2,
                                            input logic [30:0] rest);
    constraint_t c;
    c.p1 = {az, ay, ax};
    c.p2 = {bz, by, bx};
    c.w1 = w1;
    c.w2 = w2;
    c.rest = rest;
    return c;
  endfunction

  task automatic write_reg(input cfg_reg_t sel, input logic [16:0] val);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_sel <= sel;
    cfg_data <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    if (sel == REG_STIFFNESS) stiff_k = val;
    else mass_min = val[15:0];
  endtask

  task automatic drain_all();
    do @(posedge clk);
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) pending_q.push_back(random_constraint());
    drain_all();
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_q.push_back(project(cur, stiff_k, mass_min));
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          cur <= pending_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off to back the pipe up
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && accepted_cnt >= 400) begin
      hold_done = 1;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 120);
        stall_mode = $urandom_range(0, 3);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= $urandom_range(0, 3) == 0;
        2: out_stall <= $urandom_range(0, 3) != 0;
        default: out_stall <= $urandom_range(0, 1);
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    projection_t exp_r;
    logic [2:0][31:0] got1, got2;
    if (!rst && out_valid && !out_stall) begin
      got1 = {new_first_z, new_first_y, new_first_x};
      got2 = {new_second_z, new_second_y, new_second_x};
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction on output", $time);
      end else begin
        exp_r = expected_q.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (got1[i] !== exp_r.np1[i]) begin
            errors++;
            $display("%0t: new_first[%0d] expected %h actual %h", $time, i,
                     exp_r.np1[i], got1[i]);
          end
          if (got2[i] !== exp_r.np2[i]) begin
            errors++;
            $display("%0t: new_second[%0d] expected %h actual %h", $time, i,
                     exp_r.np2[i], got2[i]);
          end
        end
        if (skipped !== exp_r.skip) begin
          errors++;
          $display("%0t: skipped expected %b actual %b", $time, exp_r.skip, skipped);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_reg(REG_STIFFNESS, 17'd65536);
    write_reg(REG_MIN_MASS_SUM, 17'd1);
    // extremes, light pairs, coincident particles, pinned ends
    pending_q.push_back(make_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
      32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff, 31'd0));
    pending_q.push_back(make_pair(32'h8000_0000, 0, 0, 32'h7fff_ffff, 0, 0,
      32'h1_0000, 0, 31'h7fff_ffff));
    pending_q.push_back(make_pair(0, 32'h7fff_ffff, 0, 0, 32'h8000_0000, 0,
      0, 32'h1_0000, 31'd1 << 16));
    pending_q.push_back(make_pair(1 << 16, 2 << 16, 3 << 16, 1 << 16, 2 << 16, 3 << 16,
      32'h1_0000, 32'h1_0000, 31'd5 << 16));
    pending_q.push_back(make_pair(1 << 16, 0, 0, 0, 0, 0, 0, 0, 31'd0));
    pending_q.push_back(make_pair(3 << 16, 4 << 16, 0, 0, 0, 0,
      32'h1_0000, 32'h1_0000, 31'd2 << 16));
    pending_q.push_back(make_pair(0, 0, 0, 3 << 16, 4 << 16, 12 << 16,
      32'h1_0000, 32'h3_0000, 31'd20 << 16));
    pending_q.push_back(make_pair(32'hffff_fff0, 5, 32'h10, 7, 32'hffff_fffb, 0,
      1, 0, 31'd0));
    pending_q.push_back(make_pair(32'h7fff_0000, 32'h7fff_0000, 0, 32'h8001_0000,
      32'h8001_0000, 0, 32'hffff_ffff, 1, 31'h7fff_ffff));
    pending_q.push_back(make_pair(32'h7fff_ffff, 0, 32'h8000_0000, 0, 0, 0,
      32'h8000_0000, 32'h8000_0000, 31'd0));
    pending_q.push_back(make_pair(1, 1, 1, 0, 0, 0, 32'h0000_ffff, 32'h0000_ffff,
      31'h7fff_ffff));
    pending_q.push_back(make_pair(0, 0, 32'h8000_0000, 0, 0, 32'h7fff_ffff,
      0, 32'hffff_ffff, 31'h4000_0000));
    drain_all();
    run_random(200);
    write_reg(REG_STIFFNESS, 17'd0);
    write_reg(REG_MIN_MASS_SUM, 17'd65535);
    pending_q.push_back(make_pair(1 << 16, 0, 0, 0, 0, 0, 32'h7fff, 32'h7fff, 31'd0));
    pending_q.push_back(make_pair(1 << 16, 0, 0, 0, 0, 0, 32'h8000, 32'h7fff, 31'd0));
    run_random(150);
    write_reg(REG_STIFFNESS, 17'h1ffff);
    write_reg(REG_MIN_MASS_SUM, 17'd0);
    pending_q.push_back(make_pair(1 << 16, 0, 0, 0, 0, 0, 0, 0, 31'd0));
    run_random(200);
    write_reg(REG_STIFFNESS, 17'd32768);
    write_reg(REG_MIN_MASS_SUM, 17'd300);
    run_random(150);
    write_reg(REG_STIFFNESS, 17'($urandom_range(0, 65536)));
    write_reg(REG_MIN_MASS_SUM, 17'($urandom_range(0, 65535)));
    run_random(250);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/dcp_pkg.sv
hdl/dcp_div.sv
hdl/distance_constraint_projection_top.sv
sim/tb.sv
